/* rtl/core/yuvrgb_pkg.sv */
package yuvrgb_pkg;

  // BT.601 coefficients, signed Q2.16 fixed point (18 bits)
  localparam logic signed [17:0] ScaleVCh0 = 18'sd91881;
  localparam logic signed [17:0] ScaleUCh1 = -18'sd22553;
  localparam logic signed [17:0] ScaleVCh1 = -18'sd46801;
  localparam logic signed [17:0] ScaleUCh2 = 18'sd116129;

  localparam int TermW = 25;  // chroma product / sum width, signed
  localparam int SumW  = 27;  // luma + chroma term, signed

  localparam int CfgAddrW = 3;
  localparam logic [0:0] RegOutputMode = 1'b0;

  typedef enum logic {
    MODE_RGB888 = 1'b0,
    MODE_RGB565 = 1'b1
  } out_mode_t;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_top_left;
    logic [23:0] pixel_top_right;
    logic [23:0] pixel_bottom_left;
    logic [23:0] pixel_bottom_right;
  } out_item_t;

  typedef struct packed {
    logic signed [TermW-1:0] t0;
    logic signed [TermW-1:0] t1;
    logic signed [TermW-1:0] t2;
  } chroma_terms_t;

  typedef struct packed {
    logic [3:0][7:0] luma;   // [0] top left .. [3] bottom right
    chroma_terms_t   terms;
  } stage1_t;

endpackage

/* rtl/core/yuv420_block_to_rgb.sv */
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_valid / in_stall  | in_data  (in_item_t: 4 lumas, U, V)
// out_    | out | out_valid / out_stall| out_data (out_item_t: 4 pixels)
// cfg     | in  | psel/penable/pready  | paddr, pwdata, prdata (output_mode)
//
// Chroma products register in stage 1, then four pixel lanes feed the
// output register. One block per cycle sustained while out_stall is low.
// rst_n is synchronous, active low; clears valids and output_mode.
// A stalled output holds; stage 1 still takes a transaction if it is empty,
// so in_stall rises only when both stages are full and out_stall is high.
module yuv420_block_to_rgb (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // block input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  yuvrgb_pkg::in_item_t                 in_data,
  // pixel output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output yuvrgb_pkg::out_item_t                out_data,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [yuvrgb_pkg::CfgAddrW-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  // ---------------- register port ----------------
  yuvrgb_pkg::out_mode_t mode_r;
  yuvrgb_pkg::out_mode_t mode_nxt;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready
                & (paddr[yuvrgb_pkg::CfgAddrW-1:2] == yuvrgb_pkg::RegOutputMode);
  assign mode_nxt = cfg_wr ? yuvrgb_pkg::out_mode_t'(pwdata[0]) : mode_r;
  assign prdata   = {31'd0, mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= yuvrgb_pkg::MODE_RGB888;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_ready;   // output register can take a transaction this cycle
  logic s1_ready;
  logic in_accept;

  assign out_ready = ~out_valid_r | ~out_stall;
  assign s1_ready  = ~s1_valid_r | out_ready;
  assign in_accept = in_valid & s1_ready;
  assign in_stall  = ~s1_ready;

  always_comb begin
    priority if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_ready ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- stage 1: shared chroma terms ----------------
  yuvrgb_pkg::stage1_t s1_q;

  yuvrgb_chroma u_chroma (
    .clk     (clk),
    .load    (in_accept),
    .in_item (in_data),
    .stage_q (s1_q)
  );

  // ---------------- stage 2: four pixel lanes ----------------
  logic [3:0][23:0] lane_pix;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    yuvrgb_lane u_lane (
      .luma  (s1_q.luma[k]),
      .terms (s1_q.terms),
      .mode  (mode_r),
      .pixel (lane_pix[k])
    );
  end

  // ---------------- merge into output register ----------------
  yuvrgb_pkg::out_item_t out_data_r;
  yuvrgb_pkg::out_item_t out_data_nxt;

  always_comb begin
    out_data_nxt.pixel_top_left     = lane_pix[0];
    out_data_nxt.pixel_top_right    = lane_pix[1];
    out_data_nxt.pixel_bottom_left  = lane_pix[2];
    out_data_nxt.pixel_bottom_right = lane_pix[3];
  end

  always_ff @(posedge clk) begin
    if (out_ready & s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/yuvrgb_chroma.sv */
// Shared chroma products for the block, plus the lumas, into stage 1 registers.
module yuvrgb_chroma (
  input  logic                 clk,
  input  logic                 load,
  input  yuvrgb_pkg::in_item_t in_item,
  output yuvrgb_pkg::stage1_t  stage_q
);

  logic signed [7:0] u_s;
  logic signed [7:0] v_s;
  logic signed [yuvrgb_pkg::TermW-1:0] p_v0;
  logic signed [yuvrgb_pkg::TermW-1:0] p_u1;
  logic signed [yuvrgb_pkg::TermW-1:0] p_v1;
  logic signed [yuvrgb_pkg::TermW-1:0] p_u2;
  yuvrgb_pkg::stage1_t stage_r;
  yuvrgb_pkg::stage1_t stage_nxt;

  // x - 128 for offset binary is just the MSB inverted
  assign u_s = signed'({~in_item.chroma_u[7], in_item.chroma_u[6:0]});
  assign v_s = signed'({~in_item.chroma_v[7], in_item.chroma_v[6:0]});

  assign p_v0 = v_s * yuvrgb_pkg::ScaleVCh0;
  assign p_u1 = u_s * yuvrgb_pkg::ScaleUCh1;
  assign p_v1 = v_s * yuvrgb_pkg::ScaleVCh1;
  assign p_u2 = u_s * yuvrgb_pkg::ScaleUCh2;

  always_comb begin
    stage_nxt.luma[0]  = in_item.luma_top_left;
    stage_nxt.luma[1]  = in_item.luma_top_right;
    stage_nxt.luma[2]  = in_item.luma_bottom_left;
    stage_nxt.luma[3]  = in_item.luma_bottom_right;
    stage_nxt.terms.t0 = p_v0;
    stage_nxt.terms.t1 = p_u1 + p_v1;
    stage_nxt.terms.t2 = p_u2;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_q = stage_r;

endmodule

/* rtl/core/yuvrgb_lane.sv */
// One pixel lane: add scaled luma to the shared terms, clip, pack.
module yuvrgb_lane (
  input  logic                      [7:0] luma,
  input  yuvrgb_pkg::chroma_terms_t       terms,
  input  yuvrgb_pkg::out_mode_t           mode,
  output logic                     [23:0] pixel
);

  localparam int SumW = yuvrgb_pkg::SumW;

  function automatic logic [7:0] clip_byte(input logic signed [SumW-1:0] s);
    logic [7:0] r;
    if (s[SumW-1]) begin
      r = 8'h00;
    end else if (|s[SumW-2:24]) begin
      r = 8'hff;
    end else begin
      r = s[23:16];   // sums at or below 0xffff land on 0 here too
    end
    return r;
  endfunction

  logic signed [SumW-1:0] y_sc;
  logic signed [SumW-1:0] s0;
  logic signed [SumW-1:0] s1;
  logic signed [SumW-1:0] s2;
  logic [7:0] c0;
  logic [7:0] c1;
  logic [7:0] c2;

  assign y_sc = signed'({3'b000, luma, 16'h0000});
  assign s0   = y_sc + SumW'(terms.t0);
  assign s1   = y_sc + SumW'(terms.t1);
  assign s2   = y_sc + SumW'(terms.t2);
  assign c0   = clip_byte(s0);
  assign c1   = clip_byte(s1);
  assign c2   = clip_byte(s2);

  always_comb begin
    unique case (mode)
      yuvrgb_pkg::MODE_RGB565: pixel = {8'h00, c2[7:3], c1[7:2], c0[7:3]};
      yuvrgb_pkg::MODE_RGB888: pixel = {c2, c1, c0};
      default:                 pixel = {c2, c1, c0};
    endcase
  end

endmodule

/* rtl/core/yuvrgb_checker.sv */
module yuvrgb_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input yuvrgb_pkg::out_item_t out_data
);

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // an empty output means the pipe can always take a transaction
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("in_stall with empty output");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

endmodule

bind yuv420_block_to_rgb yuvrgb_checker u_yuvrgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
